/* sv/ofcc_pkg.sv */
// ----------------------------------------------------------------------------
// Optical flow color coder package
// Shared constants, pipeline payload types and the color wheel function.
// ----------------------------------------------------------------------------
package ofcc_pkg;

    // Number of CORDIC rotation cells (supported range 8 to 24).
    localparam int CORDIC_STAGES = 16;

    // Widths of the datapath.
    localparam int XY_W   = 28;
    localparam int MAG_W  = 25;
    localparam int NUM_W  = MAG_W + 8;
    localparam int MM_W   = 15;

    // Inverse CORDIC gain in Q30.
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    // Arctangent of 2^-i as a fraction of a full turn (2^32).
    localparam logic [31:0] ATAN_TURNS [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Payload carried through the CORDIC chain.
    typedef struct packed {
        logic                   flow_ok;
        logic                   fy_zero;
        logic                   fy_pos;
        logic                   fx_neg;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [31:0]            phase;
    } cordic_data_t;

    // Payload carried through the divider chain.
    typedef struct packed {
        logic             flow_ok;
        logic [5:0]       k0;
        logic [15:0]      frac;
        logic [NUM_W-1:0] num;
        logic [MM_W-1:0]  rem;
        logic [NUM_W-1:0] quo;
    } div_data_t;

    // Color wheel entry k (0..54) for channel ch (0 red, 1 green, 2 blue).
    function automatic logic [7:0] wheel_entry(input logic [5:0] k, input logic [1:0] ch);
        int unsigned kk;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        kk = int'(k);
        r = 0;
        g = 0;
        b = 0;
        if (kk < 15) begin
            r = 255; g = 255 * kk / 15; b = 0;
        end else if (kk < 21) begin
            r = 255 - 255 * (kk - 15) / 6; g = 255; b = 0;
        end else if (kk < 25) begin
            r = 0; g = 255; b = 255 * (kk - 21) / 4;
        end else if (kk < 36) begin
            r = 0; g = 255 - 255 * (kk - 25) / 11; b = 255;
        end else if (kk < 49) begin
            r = 255 * (kk - 36) / 13; g = 0; b = 255;
        end else if (kk < 55) begin
            r = 255; g = 0; b = 255 - 255 * (kk - 49) / 6;
        end
        case (ch)
            2'd0:    return 8'(r);
            2'd1:    return 8'(g);
            default: return 8'(b);
        endcase
    endfunction

endpackage

/* sv/ofcc_cordic_cell.sv */
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One registered rotation step that drives y toward zero and sums the phase.
// ----------------------------------------------------------------------------
module ofcc_cordic_cell
    import ofcc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  logic [4:0]   shift,
    input  logic [31:0]  angle,
    input  logic         in_v,
    input  cordic_data_t in_d,
    output logic         out_v,
    output cordic_data_t out_d
);

    logic         valid_reg;
    cordic_data_t data_reg;
    cordic_data_t data_next;

    // Rotate toward the x axis by the arctangent of 2^-shift.
    always_comb
    begin
        data_next = in_d;
        if (in_d.y > 0)
        begin
            data_next.x     = in_d.x + (in_d.y >>> shift);
            data_next.y     = in_d.y - (in_d.x >>> shift);
            data_next.phase = in_d.phase + angle;
        end
        else
        begin
            data_next.x     = in_d.x - (in_d.y >>> shift);
            data_next.y     = in_d.y + (in_d.x >>> shift);
            data_next.phase = in_d.phase - angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_v;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

    assign out_v = valid_reg;
    assign out_d = data_reg;

endmodule

/* sv/ofcc_div_cell.sv */
// ----------------------------------------------------------------------------
// Restoring divider cell
// Produces one quotient bit of the radius division per registered step.
// ----------------------------------------------------------------------------
module ofcc_div_cell
    import ofcc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic [MM_W-1:0] divisor,
    input  logic            in_v,
    input  div_data_t       in_d,
    output logic            out_v,
    output div_data_t       out_d
);

    logic            valid_reg;
    div_data_t       data_reg;
    div_data_t       data_next;
    logic [MM_W:0]   trial;
    logic            ge;

    // Bring down the next numerator bit and subtract when it fits.
    always_comb
    begin
        trial          = {in_d.rem, in_d.num[NUM_W-1]};
        ge             = (trial >= {1'b0, divisor});
        data_next      = in_d;
        data_next.rem  = ge ? MM_W'(trial - {1'b0, divisor}) : trial[MM_W-1:0];
        data_next.quo  = {in_d.quo[NUM_W-2:0], ge};
        data_next.num  = {in_d.num[NUM_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_v;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

    assign out_v = valid_reg;
    assign out_d = data_reg;

endmodule

/* sv/optical_flow_color_coder.sv */
// ----------------------------------------------------------------------------
// Optical flow color coder
// Maps each flow vector to an RGB color on the standard flow color wheel.
// ----------------------------------------------------------------------------
// The block accepts one flow vector every clock while in_stall is low and
// delivers one color per vector in order, through the input stage, the CORDIC
// cells that find angle and magnitude, the post stage, the 33-cell divider
// chain that scales the magnitude by max_motion, the color stage and the
// output register. A two-entry output buffer lets the pipeline keep moving
// while a result waits; input stall rises only once both entries are full.
// The user must write max_motion with write_enable and write_data only while
// no transfer is in flight; the block does not enforce it. Zero counts as one.
module optical_flow_color_coder
    import ofcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              write_enable,
    input  logic [MM_W-1:0]   write_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic signed [15:0] flow_x,
    input  logic signed [15:0] flow_y,
    input  logic              flow_valid,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        red,
    output logic [7:0]        green,
    output logic [7:0]        blue
);

    localparam int NS = CORDIC_STAGES;

    logic [MM_W-1:0] max_motion_reg;
    logic [MM_W-1:0] divisor;
    logic            advance;
    logic            accept;

    logic            out_valid_reg;
    logic            skid_valid_reg;
    logic [7:0]      out_reg  [3];
    logic [7:0]      skid_reg [3];

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_motion_reg <= MM_W'(2560);
        else if (write_enable)
            max_motion_reg <= write_data;
    end

    assign divisor = (max_motion_reg == '0) ? MM_W'(1) : max_motion_reg;

    // The pipeline moves whenever the skid entry is free.
    assign advance  = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;

    // Input stage: fold the vector into the right half plane.
    logic                   s0_valid_reg;
    cordic_data_t           s0_reg;
    cordic_data_t           s0_next;
    logic signed [XY_W-1:0] fx_ext;
    logic signed [XY_W-1:0] fy_ext;

    always_comb
    begin
        fx_ext          = XY_W'(flow_x) <<< 8;
        fy_ext          = XY_W'(flow_y) <<< 8;
        s0_next.flow_ok = flow_valid;
        s0_next.fy_zero = (flow_y == 16'sd0);
        s0_next.fy_pos  = (flow_y > 16'sd0);
        s0_next.fx_neg  = (flow_x < 16'sd0);
        if (flow_x < 16'sd0)
        begin
            s0_next.x     = -fx_ext;
            s0_next.y     = -fy_ext;
            s0_next.phase = HALF_TURN;
        end
        else
        begin
            s0_next.x     = fx_ext;
            s0_next.y     = fy_ext;
            s0_next.phase = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (advance)
            s0_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            s0_reg <= s0_next;
    end

    // Chain of CORDIC cells.
    logic         cv [NS+1];
    cordic_data_t cd [NS+1];

    assign cv[0] = s0_valid_reg;
    assign cd[0] = s0_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_cordic
        ofcc_cordic_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .shift   (5'(i)),
            .angle   (ATAN_TURNS[i]),
            .in_v    (cv[i]),
            .in_d    (cd[i]),
            .out_v   (cv[i+1]),
            .out_d   (cd[i+1])
        );
    end

    // Post stage: phase fix-up, gain correction and wheel position.
    logic              post_valid_reg;
    div_data_t         post_reg;
    div_data_t         post_next;
    logic [31:0]       phase_fix;
    logic [XY_W-2:0]   x_clamp;
    logic [XY_W+28:0]  mag_prod;
    logic [37:0]       pos;

    always_comb
    begin
        phase_fix = cd[NS].phase;
        if (cd[NS].fy_zero)
            phase_fix = cd[NS].fx_neg ? HALF_TURN : 32'h0;
        else if (cd[NS].fy_pos && cd[NS].phase >= 32'hC000_0000)
            phase_fix = 32'h0;
        else if (!cd[NS].fy_pos && cd[NS].phase < 32'h4000_0000)
            phase_fix = 32'hFFFF_FFFF;

        x_clamp  = (cd[NS].x < 0) ? '0 : cd[NS].x[XY_W-2:0];
        mag_prod = (XY_W+29)'(x_clamp) * (XY_W+29)'(INV_GAIN_Q30);
        pos      = 38'(phase_fix) * 38'd54;

        post_next.flow_ok = cd[NS].flow_ok;
        post_next.k0      = pos[37:32];
        post_next.frac    = pos[31:16];
        post_next.num     = {mag_prod[30 +: MAG_W], 8'd0};
        post_next.rem     = '0;
        post_next.quo     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            post_valid_reg <= 1'b0;
        else if (advance)
            post_valid_reg <= cv[NS];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            post_reg <= post_next;
    end

    // Chain of divider cells for the radius.
    logic      dv [NUM_W+1];
    div_data_t dd [NUM_W+1];

    assign dv[0] = post_valid_reg;
    assign dd[0] = post_reg;

    for (genvar j = 0; j < NUM_W; j++)
    begin : g_div
        ofcc_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .divisor (divisor),
            .in_v    (dv[j]),
            .in_d    (dd[j]),
            .out_v   (dv[j+1]),
            .out_d   (dd[j+1])
        );
    end

    // Color stage: wheel interpolation.
    logic        color_valid_reg;
    logic        color_ok_reg;
    logic        color_near_reg;
    logic [16:0] color_rad_reg;
    logic [23:0] color_c_reg  [3];
    logic [23:0] color_c_next [3];
    logic [5:0]  k1;
    logic [16:0] one_minus_f;

    always_comb
    begin
        k1          = dd[NUM_W].k0 + 6'd1;
        one_minus_f = 17'h10000 - 17'(dd[NUM_W].frac);
        for (int ch = 0; ch < 3; ch++)
        begin
            color_c_next[ch] = 24'(
                25'(one_minus_f) * 25'(wheel_entry(dd[NUM_W].k0, 2'(ch))) +
                25'(dd[NUM_W].frac) * 25'(wheel_entry(k1, 2'(ch))));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            color_valid_reg <= 1'b0;
        else if (advance)
            color_valid_reg <= dv[NUM_W];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            color_ok_reg   <= dd[NUM_W].flow_ok;
            color_near_reg <= (dd[NUM_W].quo <= NUM_W'(65536));
            color_rad_reg  <= dd[NUM_W].quo[16:0];
            color_c_reg    <= color_c_next;
        end
    end

    // Final channel values: saturation inside the unit circle, dimming outside.
    logic [7:0]  res   [3];
    logic [40:0] near_prod [3];
    logic [40:0] near_val  [3];
    logic [25:0] far_val   [3];

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            near_prod[ch] = 41'(color_rad_reg) *
                            41'(24'(255 * 65536) - color_c_reg[ch]);
            near_val[ch]  = (41'(255) << 32) - near_prod[ch];
            far_val[ch]   = 26'(color_c_reg[ch]) * 26'd3;
            if (!color_ok_reg)
                res[ch] = 8'd0;
            else if (color_near_reg)
                res[ch] = near_val[ch][39:32];
            else
                res[ch] = far_val[ch][25:18];
        end
    end

    // Output register with a skid entry behind it.
    logic take;
    logic res_v;

    assign take  = out_valid_reg && !out_stall;
    assign res_v = color_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
                skid_valid_reg <= 1'b0;
        end
        else if (res_v)
        begin
            if (out_valid_reg && !take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (take)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                out_reg <= skid_reg;
        end
        else if (res_v)
        begin
            if (out_valid_reg && !take)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = out_reg[0];
    assign green     = out_reg[1];
    assign blue      = out_reg[2];

`ifndef SYNTHESIS
    // The skid entry is only ever occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    // The skid entry fills only when a result meets a stalled output.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall && color_valid_reg))
        else $error("skid entry filled without a stalled output transfer");

    // A frozen pipeline keeps its final stage.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(color_valid_reg))
        else $error("pipeline moved while the output buffer was full");
`endif

endmodule
